@@ hdl/tti_pkg.sv @@
package tti_pkg;

    localparam int TABLE_DEPTH   = 30;
    localparam int ADC_BITS      = 12;

    localparam int READING_W     = 12;
    localparam int INDEX_W       = 5;
    localparam int ENTRY_ADC_W   = 12;
    localparam int TEMP_W        = 16;

    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int DIFF_W        = ADC_BITS + 1;
    localparam int TDIFF_W       = TEMP_W + 1;
    localparam int PROD_W        = DIFF_W + TDIFF_W;
    localparam int QUOT_W        = PROD_W + 1;
    localparam int SUM_W         = QUOT_W + 1;
    localparam int CNT_W         = $clog2(PROD_W + 1);

    localparam int DEFAULT_COUNT = 30;
    localparam int DFLT_IDX_W    = $clog2(DEFAULT_COUNT);

    localparam int TEMP_MAX      = 255;
    localparam int TEMP_MIN      = -32768;

    localparam logic FUNC_CONVERT = 1'b0;
    localparam logic FUNC_LOAD    = 1'b1;

    typedef logic        [ADC_BITS-1:0]   adc_t;
    typedef logic        [IDX_W-1:0]      idx_t;
    typedef logic        [IDX_W:0]        idx_sum_t;
    typedef logic signed [TEMP_W-1:0]     temp_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [TDIFF_W-1:0]    tdiff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic        [PROD_W-1:0]     mag_t;
    typedef logic signed [QUOT_W-1:0]     quot_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic        [CNT_W-1:0]      cnt_t;
    typedef logic        [DFLT_IDX_W-1:0] dflt_idx_t;

    typedef enum logic [3:0]
    {
        SEQ_IDLE,
        SEQ_RD_MID,
        SEQ_CMP,
        SEQ_RD_LO,
        SEQ_RD_HI,
        SEQ_CHECK,
        SEQ_MUL,
        SEQ_DIV_GO,
        SEQ_DIV_WAIT,
        SEQ_APPLY,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed
    {
        logic  en;
        idx_t  addr;
        adc_t  adc;
        temp_t temp;
    } tbl_wr_t;

    typedef struct packed
    {
        logic en;
        idx_t addr;
    } tbl_rd_t;

    typedef struct packed
    {
        adc_t  adc;
        temp_t temp;
    } tbl_rsp_t;

    typedef struct packed
    {
        logic  start;
        prod_t num;
        diff_t den;
    } div_req_t;

    typedef struct packed
    {
        logic  done;
        quot_t quot;
    } div_rsp_t;

    typedef struct packed
    {
        logic  valid;
        temp_t celsius;
        logic  oor;
    } res_t;

    localparam logic [15:0] DEFAULT_ADC [DEFAULT_COUNT] = '{
        16'd105,  16'd121,  16'd140,  16'd162,  16'd189,
        16'd222,  16'd261,  16'd308,  16'd365,  16'd434,
        16'd519,  16'd621,  16'd744,  16'd891,  16'd1067,
        16'd1272, 16'd1507, 16'd1771, 16'd2058, 16'd2357,
        16'd2657, 16'd2943, 16'd3204, 16'd3429, 16'd3614,
        16'd3760, 16'd3869, 16'd3948, 16'd4003, 16'd4039
    };

    localparam logic signed [15:0] DEFAULT_TEMP [DEFAULT_COUNT] = '{
        16'sd290, 16'sd280, 16'sd270, 16'sd260, 16'sd250,
        16'sd240, 16'sd230, 16'sd220, 16'sd210, 16'sd200,
        16'sd190, 16'sd180, 16'sd170, 16'sd160, 16'sd150,
        16'sd140, 16'sd130, 16'sd120, 16'sd110, 16'sd100,
        16'sd90,  16'sd80,  16'sd70,  16'sd60,  16'sd50,
        16'sd40,  16'sd30,  16'sd20,  16'sd10,  16'sd0
    };

    function automatic dflt_idx_t dflt_pos(input idx_t i);
        dflt_pos = (int'(i) < DEFAULT_COUNT) ? dflt_idx_t'(i) : dflt_idx_t'(DEFAULT_COUNT - 1);
    endfunction

    function automatic adc_t dflt_adc(input idx_t i);
        dflt_adc = adc_t'(DEFAULT_ADC[dflt_pos(i)]);
    endfunction

    function automatic temp_t dflt_temp(input idx_t i);
        dflt_temp = temp_t'(DEFAULT_TEMP[dflt_pos(i)]);
    endfunction

endpackage

@@ hdl/tti_table.sv @@
module tti_table
(
    input  logic               clk,
    input  logic               rst_n,
    input  tti_pkg::tbl_wr_t   wr,
    input  tti_pkg::tbl_rd_t   rd,
    output tti_pkg::tbl_rsp_t  rsp
);
    import tti_pkg::*;

    adc_t  adc_mem  [TABLE_DEPTH];
    temp_t temp_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic                   hit_reg;
    logic                   hit_next;
    adc_t                   adc_rd_reg;
    temp_t                  temp_rd_reg;
    idx_t                   addr_rd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (rd.en)
        begin
            hit_next = valid_reg[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            adc_mem[wr.addr]  <= wr.adc;
            temp_mem[wr.addr] <= wr.temp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            adc_rd_reg  <= adc_mem[rd.addr];
            temp_rd_reg <= temp_mem[rd.addr];
            addr_rd_reg <= rd.addr;
        end
    end

    // entries never loaded read as the default calibration
    assign rsp.adc  = hit_reg ? adc_rd_reg  : dflt_adc(addr_rd_reg);
    assign rsp.temp = hit_reg ? temp_rd_reg : dflt_temp(addr_rd_reg);

endmodule

@@ hdl/tti_div.sv @@
module tti_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  tti_pkg::div_req_t  req,
    output tti_pkg::div_rsp_t  rsp
);
    import tti_pkg::*;

    logic  busy_reg;
    logic  busy_next;
    logic  fin_reg;
    logic  fin_next;
    logic  done_reg;
    logic  done_next;
    cnt_t  cnt_reg;
    cnt_t  cnt_next;
    adc_t  rem_reg;
    adc_t  rem_next;
    mag_t  quo_reg;
    mag_t  quo_next;
    adc_t  dvs_reg;
    adc_t  dvs_next;
    logic  neg_reg;
    logic  neg_next;
    quot_t quot_reg;
    quot_t quot_next;

    logic [ADC_BITS:0] trial;
    logic [ADC_BITS:0] trial_sub;
    logic              ge;
    quot_t             quot_mag;

    assign trial     = {rem_reg, quo_reg[PROD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign ge        = trial >= {1'b0, dvs_reg};
    assign quot_mag  = quot_t'({1'b0, quo_reg});

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cnt_t'(PROD_W);
            rem_next  = '0;
            quo_next  = mag_t'(req.num[PROD_W-1] ? -req.num : req.num);
            dvs_next  = adc_t'(req.den[DIFF_W-1] ? -req.den : req.den);
            neg_next  = req.num[PROD_W-1] ^ req.den[DIFF_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step, one quotient bit a cycle
            rem_next = ge ? adc_t'(trial_sub) : adc_t'(trial);
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg - cnt_t'(1);
            if (cnt_reg == cnt_t'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            quot_next = neg_reg ? -quot_mag : quot_mag;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ hdl/tti_seq.sv @@
module tti_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tti_pkg::adc_t      reading,
    output logic               busy,
    output tti_pkg::tbl_rd_t   rd,
    input  tti_pkg::tbl_rsp_t  tbl,
    output tti_pkg::div_req_t  div_req,
    input  tti_pkg::div_rsp_t  div_rsp,
    output tti_pkg::res_t      res,
    input  logic               res_taken
);
    import tti_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    adc_t  rdg_reg;
    adc_t  rdg_next;
    idx_t  lo_reg;
    idx_t  lo_next;
    idx_t  hi_reg;
    idx_t  hi_next;
    adc_t  lo_adc_reg;
    adc_t  lo_adc_next;
    temp_t lo_temp_reg;
    temp_t lo_temp_next;
    logic  oor_reg;
    logic  oor_next;
    diff_t diff_reg;
    diff_t diff_next;
    tdiff_t tdiff_reg;
    tdiff_t tdiff_next;
    diff_t den_reg;
    diff_t den_next;
    prod_t prod_reg;
    prod_t prod_next;
    quot_t quot_reg;
    quot_t quot_next;
    temp_t celsius_reg;
    temp_t celsius_next;

    idx_sum_t mid_sum;
    idx_t     mid;
    logic     below;
    idx_t     lo_step;
    idx_t     hi_step;
    logic     more;
    sum_t     sum;

    assign mid_sum = idx_sum_t'(lo_reg) + idx_sum_t'(hi_reg);
    assign mid     = idx_t'(mid_sum >> 1);
    assign below   = rdg_reg < tbl.adc;
    assign lo_step = below ? lo_reg : mid;
    assign hi_step = below ? mid : hi_reg;
    assign more    = (hi_step - lo_step) > idx_t'(1);
    assign sum     = sum_t'(lo_temp_reg) + sum_t'(quot_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = (TABLE_DEPTH > 2) ? SEQ_RD_MID : SEQ_RD_LO;
                end
            end
            SEQ_RD_MID:
            begin
                state_next = SEQ_CMP;
            end
            SEQ_CMP:
            begin
                state_next = more ? SEQ_RD_MID : SEQ_RD_LO;
            end
            SEQ_RD_LO:
            begin
                state_next = SEQ_RD_HI;
            end
            SEQ_RD_HI:
            begin
                state_next = SEQ_CHECK;
            end
            SEQ_CHECK:
            begin
                state_next = oor_next ? SEQ_APPLY : SEQ_MUL;
            end
            SEQ_MUL:
            begin
                state_next = (den_reg == '0) ? SEQ_APPLY : SEQ_DIV_GO;
            end
            SEQ_DIV_GO:
            begin
                state_next = SEQ_DIV_WAIT;
            end
            SEQ_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = SEQ_APPLY;
                end
            end
            SEQ_APPLY:
            begin
                state_next = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (res_taken)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = state_reg != SEQ_IDLE;
        rd.en         = 1'b0;
        rd.addr       = lo_reg;
        div_req.start = 1'b0;
        div_req.num   = prod_reg;
        div_req.den   = den_reg;
        res.valid     = 1'b0;
        res.celsius   = celsius_reg;
        res.oor       = oor_reg;
        case (state_reg)
            SEQ_RD_MID:
            begin
                rd.en   = 1'b1;
                rd.addr = mid;
            end
            SEQ_RD_LO:
            begin
                rd.en   = 1'b1;
                rd.addr = lo_reg;
            end
            SEQ_RD_HI:
            begin
                rd.en   = 1'b1;
                rd.addr = hi_reg;
            end
            SEQ_DIV_GO:
            begin
                div_req.start = 1'b1;
            end
            SEQ_DONE:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
                rd.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rdg_next     = rdg_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        lo_adc_next  = lo_adc_reg;
        lo_temp_next = lo_temp_reg;
        oor_next     = oor_reg;
        diff_next    = diff_reg;
        tdiff_next   = tdiff_reg;
        den_next     = den_reg;
        prod_next    = prod_reg;
        quot_next    = quot_reg;
        celsius_next = celsius_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                rdg_next = reading;
                lo_next  = '0;
                hi_next  = idx_t'(TABLE_DEPTH - 1);
            end
            SEQ_CMP:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
            end
            SEQ_RD_HI:
            begin
                lo_adc_next  = tbl.adc;
                lo_temp_next = tbl.temp;
            end
            SEQ_CHECK:
            begin
                // bracket ends at a table edge with the sample beyond it
                oor_next   = ((lo_reg == '0) && (rdg_reg < lo_adc_reg))
                          || ((hi_reg == idx_t'(TABLE_DEPTH - 1)) && (rdg_reg > tbl.adc));
                diff_next  = diff_t'({1'b0, rdg_reg}) - diff_t'({1'b0, lo_adc_reg});
                tdiff_next = tdiff_t'(tbl.temp) - tdiff_t'(lo_temp_reg);
                den_next   = diff_t'({1'b0, tbl.adc}) - diff_t'({1'b0, lo_adc_reg});
                quot_next  = '0;
            end
            SEQ_MUL:
            begin
                prod_next = prod_t'(diff_reg) * prod_t'(tdiff_reg);
            end
            SEQ_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    quot_next = div_rsp.quot;
                end
            end
            SEQ_APPLY:
            begin
                if (oor_reg || (sum > sum_t'(TEMP_MAX)))
                begin
                    celsius_next = temp_t'(TEMP_MAX);
                end
                else if (sum < sum_t'(TEMP_MIN))
                begin
                    celsius_next = temp_t'(TEMP_MIN);
                end
                else
                begin
                    celsius_next = temp_t'(sum);
                end
            end
            default:
            begin
                rdg_next = rdg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdg_reg     <= rdg_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        lo_adc_reg  <= lo_adc_next;
        lo_temp_reg <= lo_temp_next;
        oor_reg     <= oor_next;
        diff_reg    <= diff_next;
        tdiff_reg   <= tdiff_next;
        den_reg     <= den_next;
        prod_reg    <= prod_next;
        quot_reg    <= quot_next;
        celsius_reg <= celsius_next;
    end

endmodule

@@ hdl/thermistor_table_interpolator_unit.sv @@
// channel | beat carries                                           | handshake
// in      | func, reading, entry_index, entry_adc, entry_value     | in_valid / in_stall
// out     | celsius, out_of_range                                  | out_valid / out_stall
//
// a load beat writes its entry in the cycle it is taken; the input is free again next cycle
// a conversion over the 30 entries runs search probes, reads the bracket, multiplies, starts the divider
// and waits for the bit-serial divide, then applies the sum and hands off the result; a sample outside
// the span or a zero-width bracket skips the divide
// reset restores the default calibration at once through per-entry valid bits, no clearing pass
// a result waits in the output register; the sequencer holds only while that is full and stalled

module thermistor_table_interpolator_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  func,
    input  logic        [tti_pkg::READING_W-1:0]  reading,
    input  logic        [tti_pkg::INDEX_W-1:0]    entry_index,
    input  logic        [tti_pkg::ENTRY_ADC_W-1:0] entry_adc,
    input  logic signed [tti_pkg::TEMP_W-1:0]     entry_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [tti_pkg::TEMP_W-1:0]     celsius,
    output logic                                  out_of_range
);
    import tti_pkg::*;

    logic      busy;
    logic      accept;
    logic      start;
    logic      res_taken;
    tbl_wr_t   tbl_wr;
    tbl_rd_t   tbl_rd;
    tbl_rsp_t  tbl_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    res_t      res;

    logic      out_valid_reg;
    logic      out_valid_next;
    temp_t     celsius_reg;
    logic      oor_reg;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;
    assign start    = accept && (func == FUNC_CONVERT);

    assign tbl_wr.en   = accept && (func == FUNC_LOAD) && (int'(entry_index) < TABLE_DEPTH);
    assign tbl_wr.addr = idx_t'(entry_index);
    assign tbl_wr.adc  = adc_t'(entry_adc);
    assign tbl_wr.temp = entry_value;

    tti_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .rd    (tbl_rd),
        .rsp   (tbl_rsp)
    );

    tti_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tti_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .reading   (adc_t'(reading)),
        .busy      (busy),
        .rd        (tbl_rd),
        .tbl       (tbl_rsp),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res       (res),
        .res_taken (res_taken)
    );

    // output register parts the sequencer from a stalled consumer
    assign res_taken = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            celsius_reg <= res.celsius;
            oor_reg     <= res.oor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign celsius      = celsius_reg;
    assign out_of_range = oor_reg;

endmodule

@@ hdl/tti_checker.sv @@
module tti_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              func,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [tti_pkg::TEMP_W-1:0] celsius,
    input logic                              out_of_range
);
    import tti_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(celsius) && $stable(out_of_range))
        else $error("stalled output beat changed");

    a_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> celsius == 16'sd255)
        else $error("out of range beat without the ceiling value");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> celsius <= 16'sd255)
        else $error("result above the ceiling");

    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_CONVERT) |=> in_stall)
        else $error("conversion taken without going busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_LOAD) |=> !in_stall)
        else $error("load beat left the input stalled");

endmodule

bind thermistor_table_interpolator_unit tti_checker u_tti_checker (.*);
